### sv/c2dvcc_pkg.sv
// package for the 2d valid cross-correlation core
// types, opcodes, register indices and size limits; no dependencies
`timescale 1ns / 1ps
package c2dvcc_pkg;

  // size limits of the line store and the kernel
  localparam int MAX_KERNEL = 5;
  localparam int MAX_WIDTH  = 256;

  localparam logic [1:0] OP_WEIGHT  = 2'd0;
  localparam logic [1:0] OP_PIXEL   = 2'd1;
  localparam logic [1:0] OP_RESTART = 2'd2;
  localparam logic [1:0] OP_UNUSED  = 2'd3;  // reserved, ignored

  localparam logic [1:0] REG_WIDTH  = 2'd0;
  localparam logic [1:0] REG_KERNEL = 2'd1;
  localparam logic [1:0] REG_BIAS   = 2'd2;

  typedef struct packed {
    logic [1:0]  opcode;
    logic signed [15:0] data_value;
    logic [4:0]  weight_index;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] result_value;
    logic [7:0]  out_row;
    logic [7:0]  out_col;
    logic        frame_last;
    logic        saturated;
  } out_item_t;

  typedef struct packed {
    logic [1:0]  index;
    logic [31:0] data;
  } cfg_item_t;

  // controller to datapath
  typedef struct packed {
    logic start;   // latch a pixel window job
    logic step;    // one multiply-accumulate tap
    logic finish;  // saturate and load the output register
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic emit;     // accepted pixel completes a window
    logic tap_last; // current tap is the final one
  } dp_sts_t;

endpackage

### sv/c2dvcc_if.sv
// valid/ready channel interfaces for the 2d cross-correlation core
// depends on c2dvcc_pkg
`timescale 1ns / 1ps
interface c2dvcc_in_if;
  logic valid;
  logic ready;
  c2dvcc_pkg::in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface c2dvcc_out_if;
  logic valid;
  logic ready;
  c2dvcc_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface c2dvcc_cfg_if;
  logic valid;
  logic ready;
  c2dvcc_pkg::cfg_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### sv/c2dvcc_ctrl.sv
// controller fsm for the cross-correlation core
// depends on c2dvcc_pkg
`timescale 1ns / 1ps
module c2dvcc_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic                out_busy_i,
  input  c2dvcc_pkg::dp_sts_t sts_i,
  output c2dvcc_pkg::dp_cmd_t cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_MAC  = 3'b010,
    ST_DONE = 3'b100
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.start = 1'b1;
          if (sts_i.emit) state_d = ST_MAC;
        end
      end
      ST_MAC: begin
        cmd_o.step = 1'b1;
        if (sts_i.tap_last) state_d = ST_DONE;
      end
      ST_DONE: begin
        if (!out_busy_i) begin
          cmd_o.finish = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

### sv/c2dvcc_dp.sv
// datapath: line store, weights, raster position, serial mac, output register
// depends on c2dvcc_pkg
`timescale 1ns / 1ps
module c2dvcc_dp (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_fire_i,
  input  c2dvcc_pkg::in_item_t   in_data_i,
  input  logic                   cfg_fire_i,
  input  c2dvcc_pkg::cfg_item_t  cfg_data_i,
  input  c2dvcc_pkg::dp_cmd_t    cmd_i,
  output c2dvcc_pkg::dp_sts_t    sts_o,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output c2dvcc_pkg::out_item_t  out_data_o
);

  localparam int MAX_KERNEL = c2dvcc_pkg::MAX_KERNEL;
  localparam int MAX_WIDTH  = c2dvcc_pkg::MAX_WIDTH;
  localparam int NW  = MAX_KERNEL * MAX_KERNEL;
  localparam int WIW = $clog2(NW);
  localparam int KW  = $clog2(MAX_KERNEL + 1);
  localparam int SW  = (MAX_KERNEL > 1) ? $clog2(MAX_KERNEL) : 1;
  localparam int CW  = $clog2(MAX_WIDTH);
  localparam int PW  = CW + 1;
  localparam int DEP = MAX_KERNEL * MAX_WIDTH;
  localparam int AW  = $clog2(DEP);
  localparam int ACW = 48;

  // configuration
  logic [8:0]  width_q;
  logic [2:0]  ksize_q;
  logic signed [31:0] bias_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q <= 9'd8;
      ksize_q <= 3'd3;
      bias_q  <= '0;
    end else if (cfg_fire_i) begin
      case (cfg_data_i.index)
        c2dvcc_pkg::REG_WIDTH:  width_q <= cfg_data_i.data[8:0];
        c2dvcc_pkg::REG_KERNEL: ksize_q <= cfg_data_i.data[2:0];
        c2dvcc_pkg::REG_BIAS:   bias_q  <= cfg_data_i.data;
        default: ;
      endcase
    end
  end

  // effective width and kernel
  logic [PW-1:0] w_eff;
  logic [KW-1:0] k_eff;
  always_comb begin
    if (width_q == 9'd0) w_eff = PW'(1);
    else if (32'(width_q) > MAX_WIDTH) w_eff = PW'(MAX_WIDTH);
    else w_eff = PW'(width_q);
    if (ksize_q == 3'd0) k_eff = KW'(1);
    else if (32'(ksize_q) > MAX_KERNEL) k_eff = KW'(MAX_KERNEL);
    else k_eff = KW'(ksize_q);
  end

  // weights, flat in flops, zero at reset
  logic signed [15:0] wgt_q [NW];
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NW; i++) wgt_q[i] <= '0;
    end else if (in_fire_i && in_data_i.opcode == c2dvcc_pkg::OP_WEIGHT
                 && 32'(in_data_i.weight_index) < NW) begin
      wgt_q[WIW'(in_data_i.weight_index)] <= in_data_i.data_value;
    end
  end

  // raster position; row kept with its slot (row mod MAX_KERNEL)
  logic [PW-1:0] row_q, col_q;
  logic [SW-1:0] slot_q;
  logic          is_pix, emit, last;
  assign is_pix = in_fire_i && in_data_i.opcode == c2dvcc_pkg::OP_PIXEL;
  assign last   = (row_q == w_eff - 1'b1) && (col_q == w_eff - 1'b1);
  assign emit   = (PW'(k_eff) <= w_eff) && (row_q >= PW'(k_eff) - 1'b1)
               && (col_q >= PW'(k_eff) - 1'b1) && (row_q < w_eff) && (col_q < w_eff);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q <= '0; col_q <= '0; slot_q <= '0;
    end else if (in_fire_i && in_data_i.opcode == c2dvcc_pkg::OP_RESTART) begin
      row_q <= '0; col_q <= '0; slot_q <= '0;
    end else if (is_pix) begin
      if (col_q >= w_eff - 1'b1) begin
        col_q <= '0;
        if (row_q >= w_eff - 1'b1) begin
          row_q <= '0; slot_q <= '0;
        end else begin
          row_q  <= row_q + 1'b1;
          slot_q <= (32'(slot_q) == MAX_KERNEL - 1) ? '0 : slot_q + 1'b1;
        end
      end else begin
        col_q <= col_q + 1'b1;
      end
    end
  end

  // line store, one write and one registered read per cycle
  logic signed [15:0] mem [DEP];
  logic signed [15:0] rd_q;
  logic [AW-1:0]      rd_addr;

  always_ff @(posedge clk_i) begin
    if (is_pix && col_q < PW'(MAX_WIDTH))
      mem[AW'(32'(slot_q) * MAX_WIDTH + 32'(col_q[CW-1:0]))] <= in_data_i.data_value;
    rd_q <= mem[rd_addr];
  end

  // window walk: tap (j,i), slot of row, column base
  logic [KW-1:0] k_q, tj_q, ti_q;
  logic [SW-1:0] sl_q;
  logic [PW-1:0] c0_q;
  logic [WIW-1:0] widx_q;
  logic [7:0]    orow_q, ocol_q;
  logic          last_q, rdv_q;
  logic signed [15:0] wrd_q;
  logic signed [31:0] prod_q;
  logic          pv_q;
  logic signed [ACW-1:0] acc_q;
  logic          tap_end;

  assign tap_end = (tj_q == k_q - 1'b1) && (ti_q == k_q - 1'b1);
  assign sts_o   = '{emit: (in_data_i.opcode == c2dvcc_pkg::OP_PIXEL) && emit,
                     tap_last: tap_end};
  assign rd_addr = AW'(32'(sl_q) * MAX_WIDTH + 32'(c0_q) + 32'(ti_q));

  logic [SW-1:0] slot0;
  always_comb begin
    // slot of row r-k+1
    if (32'(slot_q) >= 32'(k_eff) - 1) slot0 = SW'(32'(slot_q) - 32'(k_eff) + 1);
    else slot0 = SW'(32'(slot_q) + MAX_KERNEL - 32'(k_eff) + 1);
  end

  always_ff @(posedge clk_i) begin
    rdv_q <= cmd_i.step;
    wrd_q <= wgt_q[widx_q];
    pv_q  <= rdv_q;
    prod_q <= rd_q * wrd_q;
    if (cmd_i.start) begin
      k_q    <= k_eff;
      tj_q   <= '0;
      ti_q   <= '0;
      sl_q   <= slot0;
      c0_q   <= col_q - PW'(k_eff) + 1'b1;
      widx_q <= '0;
      orow_q <= 8'(row_q - PW'(k_eff) + 1'b1);
      ocol_q <= 8'(col_q - PW'(k_eff) + 1'b1);
      last_q <= last;
      acc_q  <= ACW'(bias_q);
    end else begin
      if (cmd_i.step) begin
        widx_q <= widx_q + 1'b1;
        if (ti_q == k_q - 1'b1) begin
          ti_q <= '0;
          tj_q <= tj_q + 1'b1;
          sl_q <= (32'(sl_q) == MAX_KERNEL - 1) ? '0 : sl_q + 1'b1;
        end else begin
          ti_q <= ti_q + 1'b1;
        end
      end
      if (pv_q) acc_q <= acc_q + ACW'(prod_q);
    end
  end

  // output register
  logic signed [31:0] sat_val;
  logic               sat;
  always_comb begin
    sat = 1'b0;
    sat_val = acc_q[31:0];
    if (acc_q > ACW'(32'sh7fffffff)) begin
      sat = 1'b1; sat_val = 32'sh7fffffff;
    end else if (acc_q < -(ACW'(33'sh080000000))) begin
      sat = 1'b1; sat_val = 32'sh80000000;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (cmd_i.finish) begin
      out_valid_o <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      out_data_o.result_value <= sat_val;
      out_data_o.out_row      <= orow_q;
      out_data_o.out_col      <= ocol_q;
      out_data_o.frame_last   <= last_q;
      out_data_o.saturated    <= sat;
    end
  end

endmodule

### sv/conv2d_valid_cross_correlation_core.sv
// top level of the 2d valid cross-correlation core with bias
// depends on c2dvcc_pkg, c2dvcc_if, c2dvcc_ctrl, c2dvcc_dp
//
// channel  dir  payload
// in_ch    in   opcode, data_value, weight_index
// out_ch   out  result_value, out_row, out_col, frame_last, saturated
// cfg_ch   in   index (0 width, 1 kernel size, 2 bias), data
//
// weight, restart and non-window pixel items need no mac pass
// a pixel that closes a window takes a start step, then K*K serial mac
// taps on the one line store read port, a drain of the read and multiply
// stages, then a step to load the result
// reset clears position and weights and sets config to width 8, kernel 3, bias 0; the line store is not cleared
// a waiting result holds the block until the output register frees
`timescale 1ns / 1ps
module conv2d_valid_cross_correlation_core (
  input logic          clk_i,
  input logic          rst_ni,
  c2dvcc_in_if.sink    in_ch,
  c2dvcc_out_if.source out_ch,
  c2dvcc_cfg_if.sink   cfg_ch
);

  c2dvcc_pkg::dp_cmd_t cmd;
  c2dvcc_pkg::dp_sts_t sts;
  logic in_ready, in_fire, busy;
  logic [2:0] tail_q;

  assign in_ch.ready  = in_ready;
  assign in_fire      = in_ch.valid && in_ready;
  assign cfg_ch.ready = 1'b1;

  // mac tail: counts down after the last tap until the sum is final
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) tail_q <= '0;
    else if (cmd.step && sts.tap_last) tail_q <= 3'd3;
    else if (tail_q != 3'd0) tail_q <= tail_q - 1'b1;
  end
  assign busy = (out_ch.valid && !out_ch.ready) || (tail_q != 3'd0);

  c2dvcc_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i (in_ch.valid),
    .in_ready_o (in_ready),
    .out_busy_i (busy),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  c2dvcc_dp u_dp (
    .clk_i, .rst_ni,
    .in_fire_i   (in_fire),
    .in_data_i   (in_ch.data),
    .cfg_fire_i  (cfg_ch.valid),
    .cfg_data_i  (cfg_ch.data),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_ch.valid),
    .out_ready_i (out_ch.ready),
    .out_data_o  (out_ch.data)
  );

`ifndef NO_ASSERTIONS
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (tail_q != 3'd0) |-> !in_fire) else $error("item taken during mac");
  a_finish_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.finish |-> (tail_q == 3'd0)) else $error("result before mac drained");
  a_out_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_ch.valid && !out_ch.ready) |=> out_ch.valid) else $error("result dropped");
`endif

endmodule

### dv/conv2d_valid_cross_correlation_core_test.sv
// self-checking testbench for the 2d valid cross-correlation core
// depends on c2dvcc_pkg, c2dvcc_if and the core; drives a directed table,
// random phases and a width shrink, and checks every result against a cycle-free predictor
`timescale 1ns / 1ps
module conv2d_valid_cross_correlation_core_test;

  localparam int MAX_K = c2dvcc_pkg::MAX_KERNEL;
  localparam int MAX_W = c2dvcc_pkg::MAX_WIDTH;
  localparam int DRAIN_CYCLES = 40;
  localparam int HOLDOFF_CYCLES = 400;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  always #5 clk_i = ~clk_i;

  c2dvcc_in_if  in_ch();
  c2dvcc_out_if out_ch();
  c2dvcc_cfg_if cfg_ch();

  conv2d_valid_cross_correlation_core i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // predictor state, mirrors the core's visible state
  logic [8:0]         cur_width;
  logic [2:0]         cur_ksize;
  logic signed [31:0] cur_bias;
  logic signed [15:0] row_store [MAX_K*MAX_W];
  logic signed [15:0] kernel_w [MAX_K*MAX_K];
  int unsigned        pos_row, pos_col;

  c2dvcc_pkg::out_item_t window_q[$];   // results still owed by the core
  int        err_cnt = 0;
  bit        idle_en = 1'b1;  // off during the quiet stretch
  bit        holdoff_req = 1'b0;

  // work out the effect of one accepted input item, returns 1 on a result
  function automatic bit correlate_item(input c2dvcc_pkg::in_item_t it,
                                        output c2dvcc_pkg::out_item_t res);
    int unsigned w, k, r, c, srow;
    longint acc;
    bit emit;
    w = (cur_width == 0) ? 1 : (cur_width > MAX_W) ? MAX_W : cur_width;
    k = (cur_ksize == 0) ? 1 : (cur_ksize > MAX_K) ? MAX_K : cur_ksize;
    r = pos_row;
    c = pos_col;
    res = '0;
    if (it.opcode == c2dvcc_pkg::OP_WEIGHT) begin
      if (it.weight_index < MAX_K*MAX_K) kernel_w[it.weight_index] = it.data_value;
      return 1'b0;
    end
    if (it.opcode == c2dvcc_pkg::OP_RESTART) begin
      pos_row = 0;
      pos_col = 0;
      return 1'b0;
    end
    if (it.opcode != c2dvcc_pkg::OP_PIXEL) return 1'b0;
    if (c < MAX_W) row_store[(r % MAX_K)*MAX_W + c] = it.data_value;
    emit = (k <= w) && (r >= k-1) && (c >= k-1) && (r < w) && (c < w);
    res.frame_last = (r == w-1) && (c == w-1);
    if (c >= w-1) begin
      pos_col = 0;
      pos_row = (r >= w-1) ? 0 : r+1;
    end else begin
      pos_col = c+1;
    end
    if (!emit) return 1'b0;
    acc = cur_bias;
    for (int j = 0; j < k; j++) begin
      srow = ((r - (k-1) + j) % MAX_K) * MAX_W;
      for (int i = 0; i < k; i++)
        acc += longint'(row_store[srow + c - (k-1) + i]) * longint'(kernel_w[j*k + i]);
    end
    if (acc > 64'sh7fffffff) begin
      acc = 64'sh7fffffff;
      res.saturated = 1'b1;
    end else if (acc < -64'sh80000000) begin
      acc = -64'sh80000000;
      res.saturated = 1'b1;
    end
    res.result_value = acc[31:0];
    res.out_row = 8'(r - (k-1));
    res.out_col = 8'(c - (k-1));
    return 1'b1;
  endfunction

  // offer one item, keep valid high across back-to-back items
  task automatic send_item(input c2dvcc_pkg::in_item_t it, input bit typed,
                           input c2dvcc_pkg::out_item_t typed_res);
    c2dvcc_pkg::out_item_t res;
    bit got;
    if (idle_en && $urandom_range(99) < 13) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= it;
    do @(posedge clk_i); while (!in_ch.ready);
    got = correlate_item(it, res);
    if (typed) window_q.insert(window_q.size(), typed_res);
    else if (got) window_q.insert(window_q.size(), res);
  endtask

  task automatic send_pixel_like(input logic [1:0] op, input logic [15:0] val,
                                 input logic [4:0] idx);
    c2dvcc_pkg::in_item_t it;
    it.opcode = op;
    it.data_value = val;
    it.weight_index = idx;
    send_item(it, 1'b0, '0);
  endtask

  // config writes only with the core idle
  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (window_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // valid stays high across back-to-back writes, the caller drops it
  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data.index <= idx;
    cfg_ch.data.data <= val;
    do @(posedge clk_i); while (!cfg_ch.ready);
    case (idx)
      c2dvcc_pkg::REG_WIDTH:  cur_width = val[8:0];
      c2dvcc_pkg::REG_KERNEL: cur_ksize = val[2:0];
      c2dvcc_pkg::REG_BIAS:   cur_bias  = val;
      default: ;
    endcase
  endtask

  task automatic set_config(input int w, input int k, input logic [31:0] b);
    wait_idle();
    write_reg(c2dvcc_pkg::REG_WIDTH, 32'(w));
    write_reg(c2dvcc_pkg::REG_KERNEL, 32'(k));
    write_reg(c2dvcc_pkg::REG_BIAS, b);
    cfg_ch.valid <= 1'b0;
  endtask

  function automatic logic [15:0] rand_q88();
    case ($urandom_range(9))
      0: return 16'h7fff;
      1: return 16'h8000;
      2: return 16'h0000;
      3: return 16'(int'($urandom_range(0, 1023)) - 512);
      default: return 16'($urandom);
    endcase
  endfunction

  // directed table: W=1, K=1, bias 0, so each pixel is one product
  typedef struct {
    logic [1:0]  op;
    logic [15:0] val;
    logic [4:0]  idx;
    bit          typed;
    logic [31:0] res;
  } dir_row_t;

  dir_row_t dir_tbl[] = '{
    '{c2dvcc_pkg::OP_WEIGHT,  16'h0100, 5'd0,  1'b0, 32'h0},
    '{c2dvcc_pkg::OP_PIXEL,   16'h0100, 5'd0,  1'b1, 32'h00010000},
    '{c2dvcc_pkg::OP_PIXEL,   16'h7fff, 5'd0,  1'b1, 32'h007fff00},
    '{c2dvcc_pkg::OP_PIXEL,   16'h8000, 5'd0,  1'b1, 32'hff800000},
    '{c2dvcc_pkg::OP_WEIGHT,  16'h8000, 5'd0,  1'b0, 32'h0},
    '{c2dvcc_pkg::OP_PIXEL,   16'h8000, 5'd0,  1'b1, 32'h40000000},
    '{c2dvcc_pkg::OP_PIXEL,   16'h7fff, 5'd0,  1'b1, 32'hc0008000},
    '{c2dvcc_pkg::OP_WEIGHT,  16'h1234, 5'd25, 1'b0, 32'h0},  // index out of range
    '{c2dvcc_pkg::OP_WEIGHT,  16'h4321, 5'd31, 1'b0, 32'h0},
    '{c2dvcc_pkg::OP_PIXEL,   16'h0001, 5'd31, 1'b1, 32'hffff8000},
    '{c2dvcc_pkg::OP_UNUSED,  16'hffff, 5'd7,  1'b0, 32'h0},
    '{c2dvcc_pkg::OP_RESTART, 16'h5555, 5'd1,  1'b0, 32'h0},
    '{c2dvcc_pkg::OP_PIXEL,   16'h0000, 5'd0,  1'b1, 32'h00000000},
    '{c2dvcc_pkg::OP_WEIGHT,  16'hffff, 5'd24, 1'b0, 32'h0},
    '{c2dvcc_pkg::OP_PIXEL,   16'hffff, 5'd0,  1'b0, 32'h0}
  };

  // random phases: width, kernel size, random item count
  int ph_w[] = '{8, 1, 0, 2, 3, 5, 4, 256, 300, 9, 16, 511, 6};
  int ph_k[] = '{3, 1, 0, 7, 2, 5, 5, 5,   3,   3, 4,  1,   6};
  int ph_n[] = '{80, 30, 20, 40, 60, 80, 40, 300, 40, 90, 80, 20, 80};

  // stimulus
  initial begin
    c2dvcc_pkg::in_item_t it;
    c2dvcc_pkg::out_item_t exp_res;
    logic [31:0] b;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.data = '0;
    cur_width = 9'd8;
    cur_ksize = 3'd3;
    cur_bias = '0;
    foreach (kernel_w[i]) kernel_w[i] = '0;
    foreach (row_store[i]) row_store[i] = '0;
    pos_row = 0;
    pos_col = 0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    set_config(1, 1, 32'h0);
    foreach (dir_tbl[n]) begin
      it.opcode = dir_tbl[n].op;
      it.data_value = dir_tbl[n].val;
      it.weight_index = dir_tbl[n].idx;
      exp_res = '0;
      exp_res.result_value = dir_tbl[n].res;
      exp_res.frame_last = 1'b1;
      send_item(it, dir_tbl[n].typed, exp_res);
    end

    foreach (ph_w[p]) begin
      case (p % 4)
        0: b = 32'h7fffffff;
        1: b = 32'h80000000;
        2: b = 32'h0;
        default: b = $urandom;
      endcase
      set_config(ph_w[p], ph_k[p], b);
      idle_en = (p != 4);   // quiet stretch, no gaps on either side
      send_pixel_like(c2dvcc_pkg::OP_RESTART, rand_q88(), 5'($urandom));
      for (int i = 0; i < MAX_K*MAX_K; i++)
        send_pixel_like(c2dvcc_pkg::OP_WEIGHT, rand_q88(), 5'(i));
      for (int i = 0; i < ph_n[p]; i++) begin
        if (p == 9 && i == 5) holdoff_req = 1'b1;  // let the core back up
        case ($urandom_range(99))
          0, 1: send_pixel_like(c2dvcc_pkg::OP_UNUSED, rand_q88(), 5'($urandom));
          2:    send_pixel_like(c2dvcc_pkg::OP_RESTART, rand_q88(), 5'($urandom));
          3, 4, 5: send_pixel_like(c2dvcc_pkg::OP_WEIGHT, rand_q88(), 5'($urandom));
          default: send_pixel_like(c2dvcc_pkg::OP_PIXEL, rand_q88(), 5'($urandom));
        endcase
      end
    end
    idle_en = 1'b1;

    // shrink the width mid-frame with a one-tap kernel, position wraps early
    set_config(16, 1, $urandom);
    send_pixel_like(c2dvcc_pkg::OP_RESTART, 16'h0, 5'd0);
    for (int i = 0; i < 40; i++)
      send_pixel_like(c2dvcc_pkg::OP_PIXEL, rand_q88(), 5'($urandom));
    set_config(4, 1, $urandom);
    for (int i = 0; i < 40; i++)
      send_pixel_like(c2dvcc_pkg::OP_PIXEL, rand_q88(), 5'($urandom));
    in_ch.valid <= 1'b0;

    // drain the results still owed, then wait DRAIN_CYCLES more
    @(posedge clk_i);
    while (window_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (err_cnt == 0) $display("conv2d_valid_cross_correlation_core_test OK");
    else $display("conv2d_valid_cross_correlation_core_test NOT OK");
    $finish;
  end

  // result side: random stalls, one long hold-off, field-wise check
  initial begin
    c2dvcc_pkg::out_item_t exp_res;
    int holdoff;
    bit held;
    holdoff = 0;
    held = 1'b0;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (out_ch.valid && out_ch.ready) begin
        if (window_q.size() == 0) begin
          $display("%0t: unexpected item %p", $time, out_ch.data);
          err_cnt++;
        end else begin
          exp_res = window_q.pop_front();
          if (out_ch.data.result_value !== exp_res.result_value ||
              out_ch.data.out_row !== exp_res.out_row ||
              out_ch.data.out_col !== exp_res.out_col ||
              out_ch.data.frame_last !== exp_res.frame_last ||
              out_ch.data.saturated !== exp_res.saturated) begin
            $display("%0t: mismatch expected %p actual %p", $time, exp_res, out_ch.data);
            err_cnt++;
          end
        end
      end
      if (holdoff_req && !held) begin
        held = 1'b1;
        holdoff = HOLDOFF_CYCLES;
      end
      if (holdoff > 0) begin
        holdoff--;
        out_ch.ready <= 1'b0;
      end else if (!idle_en) begin
        out_ch.ready <= 1'b1;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= 13);
      end
    end
  end

  // run limit
  initial begin
    #20ms;
    $display("conv2d_valid_cross_correlation_core_test NOT OK");
    $finish;
  end

endmodule
